/* rtl/assert_macros.svh */
// Assertion macros shared by the allocator RTL.
// Each macro samples on clk and is switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property.
`define CCA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Antecedent in one cycle, consequent checked in the next.
`define CCA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/cca_pkg.sv */
// Package for the channel capacity allocator: codes, defaults and reset values.
// No dependencies; imported by channel_capacity_allocator.
package cca_pkg;

	localparam int CHANNELS_PER_SIDE_DEF = 4;
	localparam int CLIENT_PORTS_DEF      = 4;
	localparam int ADDR_W                = 4;

	localparam logic [15:0] LIMIT_RST = 16'hFFFF;
	localparam logic [2:0]  COUNT_RST = 3'd2;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_NO_CAPACITY = 3'd1,
		ST_NO_CHANNEL  = 3'd2,
		ST_INVALID     = 3'd3,
		ST_NOT_OWNER   = 3'd4
	} status_t;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		REG_LIMIT    = 2'd0,
		REG_TX_COUNT = 2'd1,
		REG_RX_COUNT = 2'd2
	} reg_idx_t;

endpackage

/* rtl/channel_capacity_allocator.sv */
// Channel capacity allocator: channel table, running bandwidth total and APB registers.
// Depends on cca_pkg and assert_macros.svh.
//
// Usage:
// A request is taken on the rising edge where start is high and busy is low. It
// carries command, is_receive, requesting_port, request_tag, requested_bandwidth
// and channel_number. Allocate picks the lowest free channel in use on the chosen
// side if the bandwidth limit allows; free releases a channel the requester owns.
// Each request gives exactly one result: done is high for one cycle with
// reply_tag, status, granted_channel and total_assigned. The receiver cannot
// stall, so results are never held back.
// A result passes through the request stage and then the result registers before done rises.
// Throughput is one request per cycle while busy is low: the table and running total update in a
// single register stage, so a request sees the effect of the one just before it.
// Registers (APB, byte addresses 0, 4, 8): bandwidth_limit, transmit_channel_count,
// receive_channel_count; pready is always high.
// A write to either count register rebuilds the running total with a sweep over all
// 2*CHANNELS_PER_SIDE table entries, one entry per cycle, with busy high.
// Reset empties the table, zeroes the total and loads limit 65535 and counts 2.
`include "assert_macros.svh"

module channel_capacity_allocator #(
	parameter int CHANNELS_PER_SIDE = cca_pkg::CHANNELS_PER_SIDE_DEF,
	parameter int CLIENT_PORTS      = cca_pkg::CLIENT_PORTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [cca_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       start,
	output logic                       busy,
	input  logic                       command,
	input  logic                       is_receive,
	input  logic [1:0]                 requesting_port,
	input  logic [7:0]                 request_tag,
	input  logic [15:0]                requested_bandwidth,
	input  logic [3:0]                 channel_number,
	output logic                       done,
	output logic [7:0]                 reply_tag,
	output logic [2:0]                 status,
	output logic [1:0]                 granted_channel,
	output logic [15:0]                total_assigned
);
	import cca_pkg::*;

	localparam int DEPTH = 2 * CHANNELS_PER_SIDE;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CH_W  = (CHANNELS_PER_SIDE > 1) ? $clog2(CHANNELS_PER_SIDE) : 1;
	localparam int TOT_W = 16 + IDX_W;
	localparam logic [4:0]       CPS_V    = 5'(CHANNELS_PER_SIDE);
	localparam logic [IDX_W-1:0] BASE_RX  = IDX_W'(CHANNELS_PER_SIDE);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

	// Configuration registers.
	logic [15:0] limit_q;
	logic [2:0]  tx_count_q;
	logic [2:0]  rx_count_q;
	logic        cfg_wr;
	reg_idx_t    cfg_idx;

	// Request stage.
	logic        valid_s1;
	cmd_t        cmd_s1;
	logic        rx_s1;
	logic [1:0]  port_s1;
	logic [7:0]  tag_s1;
	logic [15:0] req_s1;
	logic [3:0]  chan_s1;

	// Channel table and running total.
	logic [DEPTH-1:0] entry_busy_q;
	logic [1:0]       entry_owner_q [DEPTH];
	logic [15:0]      entry_bw_q    [DEPTH];
	logic [TOT_W-1:0] total_q;
	logic             sweep_q;
	logic [IDX_W-1:0] sweep_idx_q;

	// Result registers.
	logic        done_q;
	logic [7:0]  tag_q;
	status_t     status_q;
	logic [1:0]  granted_q;
	logic [15:0] total_out_q;

	// Decision logic.
	logic [2:0]       tx_n, rx_n, side_n;
	logic             port_ok, cap_ok, chan_ok, found;
	logic [TOT_W:0]   cap_sum;
	logic [CH_W-1:0]  grant_ch;
	logic [CH_W-1:0]  chan_lo;
	logic [IDX_W-1:0] grant_idx, ch_idx, fr_idx, rd_idx;
	logic [15:0]      rd_bw;
	logic             alloc_ok, free_ok;
	status_t          st;
	logic [TOT_W-1:0] total_next;
	logic [15:0]      total_sat;
	logic             sw_rx, sw_use;
	logic [IDX_W-1:0] sw_ch;

	function automatic logic [2:0] clamp_count(input logic [2:0] cnt);
		return ({2'b00, cnt} > CPS_V) ? CPS_V[2:0] : cnt;
	endfunction

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign busy    = sweep_q;

	always_comb begin
		case (cfg_idx)
			REG_LIMIT:    prdata = {16'b0, limit_q};
			REG_TX_COUNT: prdata = {29'b0, tx_count_q};
			REG_RX_COUNT: prdata = {29'b0, rx_count_q};
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    <= LIMIT_RST;
			tx_count_q <= COUNT_RST;
			rx_count_q <= COUNT_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_LIMIT:    limit_q    <= pwdata[15:0];
				REG_TX_COUNT: tx_count_q <= pwdata[2:0];
				REG_RX_COUNT: rx_count_q <= pwdata[2:0];
				default:      ;
			endcase
		end
	end

	assign tx_n   = clamp_count(tx_count_q);
	assign rx_n   = clamp_count(rx_count_q);
	assign side_n = rx_s1 ? rx_n : tx_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1  <= cmd_t'(command);
			rx_s1   <= is_receive;
			port_s1 <= requesting_port;
			tag_s1  <= request_tag;
			req_s1  <= requested_bandwidth;
			chan_s1 <= channel_number;
		end
	end

	assign port_ok = int'(port_s1) < CLIENT_PORTS;
	assign cap_sum = {1'b0, total_q} + (TOT_W + 1)'(req_s1);
	assign cap_ok  = cap_sum <= (TOT_W + 1)'(limit_q);

	// Lowest free channel in use on the requested side.
	always_comb begin
		found    = 1'b0;
		grant_ch = '0;
		for (int c = CHANNELS_PER_SIDE - 1; c >= 0; c--) begin
			if ((5'(c) < {2'b00, side_n}) &&
			    !(rx_s1 ? entry_busy_q[c + CHANNELS_PER_SIDE] : entry_busy_q[c])) begin
				found    = 1'b1;
				grant_ch = CH_W'(c);
			end
		end
	end

	assign grant_idx = rx_s1 ? BASE_RX + IDX_W'(grant_ch) : IDX_W'(grant_ch);
	assign chan_ok   = chan_s1 < {1'b0, side_n};
	assign chan_lo   = chan_s1[CH_W-1:0];
	assign ch_idx    = rx_s1 ? BASE_RX + IDX_W'(chan_lo) : IDX_W'(chan_lo);
	assign fr_idx    = chan_ok ? ch_idx : '0;

	// The bandwidth read port is shared between the total rebuild and free requests.
	assign rd_idx = sweep_q ? sweep_idx_q : fr_idx;
	assign rd_bw  = entry_bw_q[rd_idx];

	always_comb begin
		st       = ST_OK;
		alloc_ok = 1'b0;
		free_ok  = 1'b0;
		if (!port_ok) begin
			st = ST_NOT_OWNER;
		end else if (cmd_s1 == CMD_ALLOC) begin
			if (!cap_ok) begin
				st = ST_NO_CAPACITY;
			end else if (!found) begin
				st = ST_NO_CHANNEL;
			end else begin
				alloc_ok = 1'b1;
			end
		end else begin
			if (!chan_ok) begin
				st = ST_INVALID;
			end else if (!entry_busy_q[fr_idx] || entry_owner_q[fr_idx] != port_s1) begin
				st = ST_NOT_OWNER;
			end else begin
				free_ok = 1'b1;
			end
		end
	end

	// A granted allocate never exceeds the 16-bit limit, so the sum fits the total.
	always_comb begin
		if (alloc_ok) begin
			total_next = cap_sum[TOT_W-1:0];
		end else if (free_ok) begin
			total_next = total_q - TOT_W'(rd_bw);
		end else begin
			total_next = total_q;
		end
	end

	assign total_sat = (total_next > TOT_W'(16'hFFFF)) ? 16'hFFFF : total_next[15:0];

	assign sw_rx  = sweep_idx_q >= BASE_RX;
	assign sw_ch  = sw_rx ? sweep_idx_q - BASE_RX : sweep_idx_q;
	assign sw_use = int'(sw_ch) < int'(sw_rx ? rx_n : tx_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			sweep_q     <= 1'b0;
			sweep_idx_q <= '0;
		end else if (cfg_wr && (cfg_idx == REG_TX_COUNT || cfg_idx == REG_RX_COUNT)) begin
			total_q     <= '0;
			sweep_q     <= 1'b1;
			sweep_idx_q <= '0;
		end else if (sweep_q) begin
			total_q     <= total_q + (sw_use ? TOT_W'(rd_bw) : '0);
			sweep_idx_q <= sweep_idx_q + IDX_W'(1);
			if (sweep_idx_q == LAST_IDX) begin
				sweep_q <= 1'b0;
			end
		end else if (valid_s1) begin
			total_q <= total_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_busy_q <= '0;
			for (int i = 0; i < DEPTH; i++) begin
				entry_owner_q[i] <= '0;
				entry_bw_q[i]    <= '0;
			end
		end else if (valid_s1 && alloc_ok) begin
			entry_busy_q[grant_idx]  <= 1'b1;
			entry_owner_q[grant_idx] <= port_s1;
			entry_bw_q[grant_idx]    <= req_s1;
		end else if (valid_s1 && free_ok) begin
			entry_busy_q[fr_idx]  <= 1'b0;
			entry_owner_q[fr_idx] <= '0;
			entry_bw_q[fr_idx]    <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			tag_q       <= tag_s1;
			status_q    <= st;
			granted_q   <= alloc_ok ? 2'(grant_ch) : 2'b00;
			total_out_q <= total_sat;
		end
	end

	assign done            = done_q;
	assign reply_tag       = tag_q;
	assign status          = status_q;
	assign granted_channel = granted_q;
	assign total_assigned  = total_out_q;

	`CCA_ASSERT(a_result_follows, valid_s1 |=> done_q, "request produced no result")
	`CCA_ASSERT(a_grant_only_ok, done_q && (status_q != ST_OK) |-> granted_q == 2'b00, "channel given on refusal")
	`CCA_ASSERT_NEXT(a_alloc_marks, valid_s1 && alloc_ok, $countones(entry_busy_q) == $past($countones(entry_busy_q)) + 1, "allocate did not mark one entry")
	`CCA_ASSERT_NEXT(a_free_clears, valid_s1 && free_ok, $countones(entry_busy_q) == $past($countones(entry_busy_q)) - 1, "free did not clear one entry")

endmodule
